// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file bpa_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bpa_pkg.sv -----
package bpa_pkg;

  localparam int PFN_W = 20;
  localparam int ORD_W = 4;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_REFUSED   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_INIT     = 4'd1,
    CMD_LOAD     = 4'd2,
    CMD_A_SCAN   = 4'd3,
    CMD_A_UNLINK = 4'd4,
    CMD_A_SPLIT  = 4'd5,
    CMD_F_CHECK  = 4'd6,
    CMD_F_READ   = 4'd7,
    CMD_F_MERGE  = 4'd8,
    CMD_F_PUSH   = 4'd9,
    CMD_F_LINK   = 4'd10,
    CMD_DONE     = 4'd11
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    status_e st;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic is_free;
    logic bad_order;
    logic found;
    logic k_gt_ord;
    logic range_ok;
    logic mark;
    logic k_lt_top;
    logic bud_in_range;
    logic bud_ok;
    logic out_free;
  } dp_flags_t;

endpackage

// ----- src/buddy_page_allocator.sv -----
// Buddy page allocator. Requests arrive as beats on the s_axis channel:
// tuser selects allocate (0) or free (1), tdata carries the block order and,
// for a free, the absolute page frame number. Each request gives one result
// beat on m_axis: tuser holds the status, tdata the granted page frame number
// (zero unless an allocate succeeds). The user writes region_base_page through
// the cfg channel only while the block is idle; the block does not enforce it.
// cfg_ready_o is always high. Requests are handled one at a time: an allocate
// scans the free lists, unlinks the head block and splits it once per order
// above the request; a free checks the range and mark, merges with its buddy
// once per order while the buddy is free, then pushes and links the block.
// The result then goes to the output register. After reset the block sweeps
// its memories to lay out the top-order free list, with s_axis_tready low. A
// result waiting on a stalled receiver does not block acceptance of the next
// request, but that request finishes only when the output register is taken.
module buddy_page_allocator #(
  parameter int NUM_PAGES  = 4096,
  parameter int NUM_ORDERS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // block_order[3:0], page_number[23:4]
  input  logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // granted_page[19:0], zero[23:20]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);

  bpa_pkg::ctl_cmd_t  cmd;
  bpa_pkg::dp_flags_t flags;
  logic [19:0]        page;
  bpa_pkg::status_e   status;

  bpa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .flags_i(flags), .cmd_o(cmd)
  );

  bpa_dpath #(.NumPages(NUM_PAGES), .NumOrders(NUM_ORDERS)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .flags_o(flags),
    .cfg_valid_i, .cfg_data_i,
    .in_tdata_i(s_axis_tdata), .in_tuser_i(s_axis_tuser[0]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_page_o(page), .out_status_o(status)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {4'b0000, page};
  assign m_axis_tuser = status;

endmodule

// ----- src/bpa_ram.sv -----
module bpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bpa_ctrl.sv -----
module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpa_pkg::dp_flags_t  flags_i,
  output bpa_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_INIT    = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_DECODE  = 14'b00000000000100,
    S_A_SCAN  = 14'b00000000001000,
    S_A_UNL   = 14'b00000000010000,
    S_A_SPLIT = 14'b00000000100000,
    S_F_CHK   = 14'b00000001000000,
    S_F_MARK  = 14'b00000010000000,
    S_F_LOOP  = 14'b00000100000000,
    S_F_BUD   = 14'b00001000000000,
    S_F_PUSH  = 14'b00010000000000,
    S_F_LINK  = 14'b00100000000000,
    S_DONE    = 14'b01000000000000,
    S_SPARE   = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  bpa_pkg::status_e st_q, st_d;

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    cmd_o.op   = bpa_pkg::CMD_NONE;
    cmd_o.st   = st_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.op = bpa_pkg::CMD_INIT;
        if (flags_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = bpa_pkg::CMD_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags_i.bad_order) begin
          st_d    = bpa_pkg::ST_BAD_ORDER;
          state_d = S_DONE;
        end else if (flags_i.is_free) begin
          state_d = S_F_CHK;
        end else begin
          state_d = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (flags_i.found) begin
          cmd_o.op = bpa_pkg::CMD_A_SCAN;
          state_d  = S_A_UNL;
        end else begin
          st_d    = bpa_pkg::ST_EMPTY;
          state_d = S_DONE;
        end
      end
      S_A_UNL: begin
        cmd_o.op = bpa_pkg::CMD_A_UNLINK;
        state_d  = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (flags_i.k_gt_ord) begin
          cmd_o.op = bpa_pkg::CMD_A_SPLIT;
        end else begin
          st_d    = bpa_pkg::ST_OK;
          state_d = S_DONE;
        end
      end
      S_F_CHK: begin
        cmd_o.op = bpa_pkg::CMD_F_CHECK;
        if (flags_i.range_ok) begin
          state_d = S_F_MARK;
        end else begin
          st_d    = bpa_pkg::ST_REFUSED;
          state_d = S_DONE;
        end
      end
      S_F_MARK: begin
        if (flags_i.mark) begin
          st_d    = bpa_pkg::ST_REFUSED;
          state_d = S_DONE;
        end else begin
          state_d = S_F_LOOP;
        end
      end
      S_F_LOOP: begin
        if (flags_i.k_lt_top && flags_i.bud_in_range) begin
          cmd_o.op = bpa_pkg::CMD_F_READ;
          state_d  = S_F_BUD;
        end else begin
          state_d = S_F_PUSH;
        end
      end
      S_F_BUD: begin
        if (flags_i.bud_ok) begin
          cmd_o.op = bpa_pkg::CMD_F_MERGE;
          state_d  = S_F_LOOP;
        end else begin
          state_d = S_F_PUSH;
        end
      end
      S_F_PUSH: begin
        cmd_o.op = bpa_pkg::CMD_F_PUSH;
        state_d  = S_F_LINK;
      end
      S_F_LINK: begin
        cmd_o.op = bpa_pkg::CMD_F_LINK;
        st_d     = bpa_pkg::ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd_o.op = bpa_pkg::CMD_DONE;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      st_q    <= bpa_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

// ----- src/bpa_dpath.sv -----
module bpa_dpath #(
  parameter int NumPages  = 4096,
  parameter int NumOrders = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpa_pkg::ctl_cmd_t                   cmd_i,
  output bpa_pkg::dp_flags_t                  flags_o,
  input  logic                                cfg_valid_i,
  input  logic [bpa_pkg::PFN_W-1:0]           cfg_data_i,
  input  logic [bpa_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  input  logic                                in_tuser_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bpa_pkg::PFN_W-1:0]           out_page_o,
  output bpa_pkg::status_e                    out_status_o
);

  localparam int PW    = $clog2(NumPages);
  localparam int LW    = PW + 1;
  localparam int OW    = $clog2(NumOrders);
  localparam int OrdW  = bpa_pkg::ORD_W;
  localparam int PfnW  = bpa_pkg::PFN_W;
  localparam int Top   = NumOrders - 1;
  localparam int BSize = 1 << Top;
  localparam int NBlk  = NumPages >> Top;
  localparam int Last  = NBlk * BSize;
  localparam logic [LW-1:0] Nil = LW'(NumPages);

  logic                req_q;
  logic [OrdW-1:0]     ord_q, k_q;
  logic [PfnW-1:0]     pn_q, base_q;
  logic [PW-1:0]       pg_q, cnt_q;
  logic [LW-1:0]       h_q;
  logic [LW-1:0]       head_q [NumOrders];
  logic                ovalid_q;
  logic [PfnW-1:0]     gpage_q;
  bpa_pkg::status_e    ostat_q;

  logic                nx_we, pv_we, mo_we;
  logic [PW-1:0]       nx_wa, pv_wa, mo_wa, nx_ra, pv_ra, mo_ra;
  logic [LW-1:0]       nx_wd, pv_wd, nx_rd, pv_rd;
  logic [OrdW:0]       mo_wd, mo_rd;

  logic                found;
  logic [OW-1:0]       kf_i;
  logic [OW-1:0]       k_i, kn_i;
  logic [OrdW-1:0]     kn;
  logic [31:0]         q32, bud32, ci;
  logic                q_in;
  logic [PW-1:0]       bud_a;
  logic [PfnW:0]       diff;
  logic                ini_top;

  assign k_i   = k_q[OW-1:0];
  assign kn    = k_q - OrdW'(1);
  assign kn_i  = kn[OW-1:0];
  assign q32   = 32'(pg_q) + (32'd1 << kn);
  assign q_in  = q32 < 32'(NumPages);
  assign bud32 = 32'(pg_q) ^ (32'd1 << k_q);
  assign bud_a = bud32[PW-1:0];
  assign diff  = {1'b0, pn_q} - {1'b0, base_q};
  assign ci    = 32'(cnt_q);
  assign ini_top = ((ci & 32'(BSize - 1)) == 32'd0) && (ci < 32'(Last));

  // Lowest non-empty free list at or above the requested order.
  always_comb begin
    found = 1'b0;
    kf_i  = '0;
    for (int j = NumOrders - 1; j >= 0; j--) begin
      if (32'(j) >= 32'(ord_q) && head_q[j] != Nil) begin
        found = 1'b1;
        kf_i  = OW'(j);
      end
    end
  end

  always_comb begin
    nx_we = 1'b0; nx_wa = pg_q; nx_wd = Nil; nx_ra = pg_q;
    pv_we = 1'b0; pv_wa = pg_q; pv_wd = Nil; pv_ra = pg_q;
    mo_we = 1'b0; mo_wa = pg_q; mo_wd = '0;  mo_ra = pg_q;
    case (cmd_i.op)
      bpa_pkg::CMD_INIT: begin
        nx_we = 1'b1; nx_wa = cnt_q;
        pv_we = 1'b1; pv_wa = cnt_q;
        mo_we = 1'b1; mo_wa = cnt_q;
        if (ini_top) begin
          nx_wd = (ci + 32'(BSize) < 32'(Last)) ? LW'(ci + 32'(BSize)) : Nil;
          pv_wd = (ci == 32'd0) ? Nil : LW'(ci - 32'(BSize));
          mo_wd = {1'b1, OrdW'(Top)};
        end
      end
      bpa_pkg::CMD_A_SCAN: begin
        nx_ra = head_q[kf_i][PW-1:0];
      end
      bpa_pkg::CMD_A_UNLINK: begin
        // The block taken is the list head, so only its successor is patched.
        if (nx_rd < Nil) begin
          pv_we = 1'b1; pv_wa = nx_rd[PW-1:0]; pv_wd = Nil;
        end
        mo_we = 1'b1;
      end
      bpa_pkg::CMD_A_SPLIT: begin
        if (q_in) begin
          nx_we = 1'b1; nx_wa = q32[PW-1:0]; nx_wd = head_q[kn_i];
          pv_we = 1'b1; pv_wa = q32[PW-1:0];
          mo_we = 1'b1; mo_wa = q32[PW-1:0]; mo_wd = {1'b1, kn};
        end
      end
      bpa_pkg::CMD_F_CHECK: begin
        mo_ra = diff[PW-1:0];
      end
      bpa_pkg::CMD_F_READ: begin
        nx_ra = bud_a; pv_ra = bud_a; mo_ra = bud_a;
      end
      bpa_pkg::CMD_F_MERGE: begin
        if (pv_rd < Nil) begin
          nx_we = 1'b1; nx_wa = pv_rd[PW-1:0]; nx_wd = nx_rd;
        end
        if (nx_rd < Nil) begin
          pv_we = 1'b1; pv_wa = nx_rd[PW-1:0]; pv_wd = pv_rd;
        end
        mo_we = 1'b1; mo_wa = bud_a;
      end
      bpa_pkg::CMD_F_PUSH: begin
        nx_we = 1'b1; nx_wd = head_q[k_i];
        pv_we = 1'b1;
        mo_we = 1'b1; mo_wd = {1'b1, k_q};
      end
      bpa_pkg::CMD_F_LINK: begin
        if (h_q < Nil) begin
          pv_we = 1'b1; pv_wa = h_q[PW-1:0]; pv_wd = {1'b0, pg_q};
        end
      end
      default: begin
      end
    endcase
  end

  bpa_ram #(.Width(LW), .Depth(NumPages)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd)
  );
  bpa_ram #(.Width(LW), .Depth(NumPages)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(pv_ra), .rdata_o(pv_rd)
  );
  bpa_ram #(.Width(OrdW + 1), .Depth(NumPages)) u_mark (
    .clk_i, .we_i(mo_we), .waddr_i(mo_wa), .wdata_i(mo_wd), .raddr_i(mo_ra), .rdata_o(mo_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q    <= bpa_pkg::REQ_ALLOC;
      ord_q    <= '0;
      k_q      <= '0;
      pn_q     <= '0;
      base_q   <= '0;
      pg_q     <= '0;
      cnt_q    <= '0;
      h_q      <= Nil;
      ovalid_q <= 1'b0;
      gpage_q  <= '0;
      ostat_q  <= bpa_pkg::ST_OK;
      for (int j = 0; j < NumOrders; j++) begin
        head_q[j] <= (j == Top && NBlk > 0) ? LW'(0) : Nil;
      end
    end else begin
      if (cfg_valid_i) base_q <= cfg_data_i;
      if (out_ready_i && cmd_i.op != bpa_pkg::CMD_DONE) ovalid_q <= 1'b0;
      case (cmd_i.op)
        bpa_pkg::CMD_INIT: begin
          cnt_q <= cnt_q + PW'(1);
        end
        bpa_pkg::CMD_LOAD: begin
          req_q <= in_tuser_i;
          ord_q <= in_tdata_i[OrdW-1:0];
          pn_q  <= in_tdata_i[OrdW+PfnW-1:OrdW];
        end
        bpa_pkg::CMD_A_SCAN: begin
          pg_q <= head_q[kf_i][PW-1:0];
          k_q  <= OrdW'(kf_i);
        end
        bpa_pkg::CMD_A_UNLINK: begin
          head_q[k_i] <= nx_rd;
        end
        bpa_pkg::CMD_A_SPLIT: begin
          k_q <= kn;
          if (q_in) head_q[kn_i] <= LW'(q32);
        end
        bpa_pkg::CMD_F_CHECK: begin
          pg_q <= diff[PW-1:0];
          k_q  <= ord_q;
        end
        bpa_pkg::CMD_F_MERGE: begin
          if (!(pv_rd < Nil)) head_q[k_i] <= nx_rd;
          pg_q <= pg_q & bud_a;
          k_q  <= k_q + OrdW'(1);
        end
        bpa_pkg::CMD_F_PUSH: begin
          head_q[k_i] <= {1'b0, pg_q};
          h_q         <= head_q[k_i];
        end
        bpa_pkg::CMD_DONE: begin
          ovalid_q <= 1'b1;
          ostat_q  <= cmd_i.st;
          gpage_q  <= (cmd_i.st == bpa_pkg::ST_OK && req_q == bpa_pkg::REQ_ALLOC)
                      ? PfnW'(base_q + PfnW'(pg_q)) : '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign flags_o.init_last    = cnt_q == PW'(NumPages - 1);
  assign flags_o.is_free      = req_q == bpa_pkg::REQ_FREE;
  assign flags_o.bad_order    = ord_q > OrdW'(Top);
  assign flags_o.found        = found;
  assign flags_o.k_gt_ord     = k_q > ord_q;
  assign flags_o.range_ok     = !diff[PfnW] && (32'(diff[PfnW-1:0]) < 32'(NumPages));
  assign flags_o.mark         = mo_rd[OrdW];
  assign flags_o.k_lt_top     = k_q < OrdW'(Top);
  assign flags_o.bud_in_range = bud32 < 32'(NumPages);
  assign flags_o.bud_ok       = mo_rd[OrdW] && (mo_rd[OrdW-1:0] == k_q);
  assign flags_o.out_free     = !ovalid_q || out_ready_i;

  assign out_valid_o  = ovalid_q;
  assign out_page_o   = gpage_q;
  assign out_status_o = ostat_q;

endmodule

// ----- src/bpa_checker.sv -----
`include "assert_macros.svh"

module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result beat dropped while stalled")
  `ASSERT_RST(a_page_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != bpa_pkg::ST_OK |-> m_axis_tdata == 24'd0, "nonzero page on failed request")
  `ASSERT_RST(a_one_at_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid && !s_axis_tready, "activity during reset")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
